// ===== design/dtm_pkg.sv =====
// ----------------------------------------------------------------------------
// dtm_pkg
// Shared constants, codes and types of the dirty tile marker.
// ----------------------------------------------------------------------------
`default_nettype none

package dtm_pkg;

  // Grid geometry.
  localparam int TILES_WIDE = 22;
  localparam int TILES_HIGH = 14;
  localparam int TILE_SHIFT = 4;

  // Fixed field widths.
  localparam int PX_W    = 16;
  localparam int FUNC_W  = 2;
  localparam int RDROW_W = 4;
  localparam int OUT_W   = 22;

  localparam int ROW_W = $clog2(TILES_HIGH);
  localparam int EXT_W = (TILES_WIDE > OUT_W) ? TILES_WIDE : OUT_W;

  // Clipping limits in tile coordinates.
  localparam logic signed [PX_W-1:0] COL_LAST = PX_W'(TILES_WIDE - 1);
  localparam logic signed [PX_W-1:0] COL_END  = PX_W'(TILES_WIDE - 2);
  localparam logic signed [PX_W-1:0] ROW_CNT  = PX_W'(TILES_HIGH);
  localparam logic signed [PX_W-1:0] ROW_END  = PX_W'(TILES_HIGH - 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MARK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_RDWAIT
  } state_e;

  // Outcome of clipping one mark rectangle.
  typedef struct packed {
    logic                  reject;
    logic                  empty;
    logic [ROW_W-1:0]      y_first;
    logic [ROW_W-1:0]      y_last;
    logic [TILES_WIDE-1:0] cols;
  } clip_t;

endpackage

`default_nettype wire

// ===== design/dtm_ram.sv =====
// ----------------------------------------------------------------------------
// dtm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/dtm_clip.sv =====
// ----------------------------------------------------------------------------
// dtm_clip
// Converts a pixel rectangle to tile coordinates and clips it to the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_clip (
  input  wire logic signed [dtm_pkg::PX_W-1:0] left_px_i,
  input  wire logic signed [dtm_pkg::PX_W-1:0] top_px_i,
  input  wire logic signed [dtm_pkg::PX_W-1:0] right_px_i,
  input  wire logic signed [dtm_pkg::PX_W-1:0] bottom_px_i,
  output dtm_pkg::clip_t                       clip_o
);

  logic signed [dtm_pkg::PX_W-1:0] xt1, yt1, xt2, yt2;
  logic signed [dtm_pkg::PX_W-1:0] xs, ys, xe, ye;

  // The arithmetic shift is a floor division for negative corners too.
  assign xt1 = left_px_i >>> dtm_pkg::TILE_SHIFT;
  assign yt1 = top_px_i >>> dtm_pkg::TILE_SHIFT;
  assign xt2 = right_px_i >>> dtm_pkg::TILE_SHIFT;
  assign yt2 = bottom_px_i >>> dtm_pkg::TILE_SHIFT;

  always_comb begin
    xs = xt1[dtm_pkg::PX_W-1] ? '0 : xt1;
    ys = yt1[dtm_pkg::PX_W-1] ? '0 : yt1;
    xe = (xt2 >= dtm_pkg::COL_LAST) ? dtm_pkg::COL_END : xt2;
    ye = (yt2 >= dtm_pkg::ROW_CNT) ? dtm_pkg::ROW_END : yt2;

    // The last tile column is never usable as a start and never marked.
    clip_o.reject = (xt1 >= dtm_pkg::COL_LAST) || (yt1 > dtm_pkg::ROW_CNT) ||
                    xt2[dtm_pkg::PX_W-1] || yt2[dtm_pkg::PX_W-1];
    clip_o.empty   = (xs > xe) || (ys > ye);
    clip_o.y_first = ys[dtm_pkg::ROW_W-1:0];
    clip_o.y_last  = ye[dtm_pkg::ROW_W-1:0];
    for (int i = 0; i < dtm_pkg::TILES_WIDE; i++) begin
      clip_o.cols[i] = ($signed(dtm_pkg::PX_W'(i)) >= xs) &&
                       ($signed(dtm_pkg::PX_W'(i)) <= xe);
    end
  end

endmodule

`default_nettype wire

// ===== design/dirty_tile_marker.sv =====
// ----------------------------------------------------------------------------
// dirty_tile_marker
// Grid of tile update marks held in a row-wide RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its one result shows
// on accepted_o and row_marks_o for exactly one cycle while done_o is high;
// the receiver cannot hold it off.
// A mark covering n tile rows walks the RAM one row per cycle: the read of
// a row overlaps the write-back of the row before it. Busy stays high
// through the walk and the flush state that follows it, and done_o is
// registered from the flush state.
// A read is busy in the read-wait state; its answer is registered from the
// RAM read data. A clear, a rejected or empty mark, an out-of-range read row
// and an unused function code answer on the next cycle without asserting busy.
// A new item may be taken in the cycle that shows the previous result.
// Reset clears one valid flag per row, so all marks read as zero at once;
// a clear does the same. The RAM itself is never swept.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_tile_marker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [dtm_pkg::FUNC_W-1:0]          func_i,
  input  wire logic signed [dtm_pkg::PX_W-1:0]     left_px_i,
  input  wire logic signed [dtm_pkg::PX_W-1:0]     top_px_i,
  input  wire logic signed [dtm_pkg::PX_W-1:0]     right_px_i,
  input  wire logic signed [dtm_pkg::PX_W-1:0]     bottom_px_i,
  input  wire logic [dtm_pkg::RDROW_W-1:0]         read_row_i,
  output logic                                     done_o,
  output logic                                     accepted_o,
  output logic [dtm_pkg::OUT_W-1:0]                row_marks_o
);

  dtm_pkg::state_e state_q, state_d;
  dtm_pkg::clip_t  clip;

  logic [dtm_pkg::ROW_W-1:0]      y_q, y_d;
  logic [dtm_pkg::ROW_W-1:0]      y_last_q, y_last_d;
  logic [dtm_pkg::TILES_WIDE-1:0] cols_q, cols_d;
  logic                           rowvalid_q, rowvalid_d;
  logic [dtm_pkg::TILES_HIGH-1:0] valid_q, valid_d;
  logic                           wr_pend_q, wr_pend_d;
  logic [dtm_pkg::ROW_W-1:0]      wr_row_q, wr_row_d;
  logic                           done_q, done_d;
  logic                           accepted_q, accepted_d;
  logic [dtm_pkg::OUT_W-1:0]      row_marks_q, row_marks_d;

  logic                           rd_en;
  logic [dtm_pkg::ROW_W-1:0]      rd_addr;
  logic [dtm_pkg::TILES_WIDE-1:0] rd_data;
  logic [dtm_pkg::TILES_WIDE-1:0] row_cur;
  logic [dtm_pkg::TILES_WIDE-1:0] wr_data;
  logic [dtm_pkg::EXT_W-1:0]      row_ext;
  logic                           take;
  logic                           row_in_range;

  dtm_clip u_clip (
    .left_px_i  (left_px_i),
    .top_px_i   (top_px_i),
    .right_px_i (right_px_i),
    .bottom_px_i(bottom_px_i),
    .clip_o     (clip)
  );

  dtm_ram #(
    .WIDTH(dtm_pkg::TILES_WIDE),
    .DEPTH(dtm_pkg::TILES_HIGH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_pend_q),
    .waddr_i(wr_row_q),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign busy         = (state_q != dtm_pkg::ST_IDLE);
  assign take         = start && !busy;
  assign row_in_range = (32'(read_row_i) < 32'(dtm_pkg::TILES_HIGH));

  // A row that was never written since reset or clear reads as zero.
  assign row_cur = rowvalid_q ? rd_data : '0;
  assign wr_data = row_cur | cols_q;
  assign row_ext = dtm_pkg::EXT_W'(row_cur);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtm_pkg::ST_IDLE: begin
        if (take) begin
          unique case (func_i)
            dtm_pkg::FUNC_MARK: begin
              if (!clip.reject && !clip.empty) begin
                state_d = dtm_pkg::ST_WALK;
              end
            end
            dtm_pkg::FUNC_READ: begin
              if (row_in_range) begin
                state_d = dtm_pkg::ST_RDWAIT;
              end
            end
            default: state_d = dtm_pkg::ST_IDLE;
          endcase
        end
      end
      dtm_pkg::ST_WALK: begin
        if (y_q == y_last_q) begin
          state_d = dtm_pkg::ST_FLUSH;
        end
      end
      dtm_pkg::ST_FLUSH:  state_d = dtm_pkg::ST_IDLE;
      dtm_pkg::ST_RDWAIT: state_d = dtm_pkg::ST_IDLE;
      default:            state_d = dtm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = y_q;
    y_d         = y_q;
    y_last_d    = y_last_q;
    cols_d      = cols_q;
    rowvalid_d  = rowvalid_q;
    valid_d     = valid_q;
    done_d      = 1'b0;
    accepted_d  = 1'b0;
    row_marks_d = '0;
    wr_pend_d   = (state_q == dtm_pkg::ST_WALK);
    wr_row_d    = y_q;

    if (wr_pend_q) begin
      valid_d[wr_row_q] = 1'b1;
    end

    unique case (state_q)
      dtm_pkg::ST_IDLE: begin
        if (take) begin
          unique case (func_i)
            dtm_pkg::FUNC_MARK: begin
              if (clip.reject) begin
                done_d = 1'b1;
              end else if (clip.empty) begin
                done_d     = 1'b1;
                accepted_d = 1'b1;
              end else begin
                y_d      = clip.y_first;
                y_last_d = clip.y_last;
                cols_d   = clip.cols;
              end
            end
            dtm_pkg::FUNC_READ: begin
              if (row_in_range) begin
                rd_en      = 1'b1;
                rd_addr    = dtm_pkg::ROW_W'(read_row_i);
                rowvalid_d = valid_q[dtm_pkg::ROW_W'(read_row_i)];
              end else begin
                done_d = 1'b1;
              end
            end
            dtm_pkg::FUNC_CLEAR: begin
              valid_d = '0;
              done_d  = 1'b1;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      dtm_pkg::ST_WALK: begin
        // Read this row while the previous row is written back.
        rd_en      = 1'b1;
        rowvalid_d = valid_q[y_q];
        if (y_q != y_last_q) begin
          y_d = y_q + dtm_pkg::ROW_W'(1);
        end
      end
      dtm_pkg::ST_FLUSH: begin
        done_d     = 1'b1;
        accepted_d = 1'b1;
      end
      dtm_pkg::ST_RDWAIT: begin
        done_d      = 1'b1;
        row_marks_d = row_ext[dtm_pkg::OUT_W-1:0];
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dtm_pkg::ST_IDLE;
      valid_q   <= '0;
      wr_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      wr_pend_q <= wr_pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q         <= y_d;
    y_last_q    <= y_last_d;
    cols_q      <= cols_d;
    rowvalid_q  <= rowvalid_d;
    wr_row_q    <= wr_row_d;
    accepted_q  <= accepted_d;
    row_marks_q <= row_marks_d;
  end

  assign done_o      = done_q;
  assign accepted_o  = accepted_q;
  assign row_marks_o = row_marks_q;

  // A write-back only follows a walk step, never while a new item can enter.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == dtm_pkg::ST_WALK || state_q == dtm_pkg::ST_FLUSH))
    else $error("RAM write-back pending while idle");

  // The row walk never passes the last clipped row.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtm_pkg::ST_WALK) |-> (y_q <= y_last_q))
    else $error("row walk beyond last row");

  // A finished walk reports an accepted mark on the next cycle.
  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtm_pkg::ST_FLUSH) |=> (done_o && accepted_o))
    else $error("mark walk finished without accepted result");

  // A row read answers with accepted low in the cycle after the read-wait state.
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtm_pkg::ST_RDWAIT) |=> (done_o && !accepted_o))
    else $error("row read did not produce its result");

endmodule

`default_nettype wire
